// ===== hdl/t3vc_pkg.sv =====
// Shared types, register indexes and compensator coefficients for the
// type-3 voltage compensator. No dependencies; every other file imports it.

package t3vc_pkg;

  localparam int ADC_WIDTH_DEF = 12;

  localparam logic [12:0] CAL_GAIN_RST   = 13'd4096;
  localparam logic [12:0] BOOST_MAX_RST  = 13'd3686;
  localparam logic [12:0] MAX_BUCK_RST   = 13'd3809;
  localparam logic [15:0] PERIOD_RST     = 16'd32768;

  localparam logic signed [16:0] KB0 = 17'sd6144;
  localparam logic signed [16:0] KB1 = -17'sd5952;
  localparam logic signed [16:0] KB2 = -17'sd6141;
  localparam logic signed [16:0] KB3 = 17'sd5955;
  localparam logic signed [16:0] KA1 = 17'sd5080;
  localparam logic signed [16:0] KA2 = -17'sd1043;
  localparam logic signed [16:0] KA3 = 17'sd59;

  typedef enum logic [2:0] {
    REG_CAL_GAIN   = 3'd0,
    REG_CAL_OFFSET = 3'd1,
    REG_VREF       = 3'd2,
    REG_BOOST_MAX  = 3'd3,
    REG_BOOST_MIN  = 3'd4,
    REG_BUCK_MAX   = 3'd5,
    REG_BUCK_MIN   = 3'd6,
    REG_PERIOD     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [12:0]        cal_gain;
    logic signed [12:0] cal_offset;
    logic [11:0]        vref;
    logic [12:0]        boost_max_duty;
    logic [12:0]        boost_floor_duty;
    logic [12:0]        buck_run_duty;
    logic [12:0]        min_buck_duty;
    logic [15:0]        period;
  } cfg_t;

  typedef struct packed {
    logic acc_load;
    logic acc_add;
  } mac_ctl_t;

  function automatic logic signed [16:0] ka_coef(input logic [1:0] idx);
    case (idx)
      2'd0: ka_coef = KA1;
      2'd1: ka_coef = KA2;
      2'd2: ka_coef = KA3;
      default: ka_coef = 17'sd0;
    endcase
  endfunction

  function automatic logic signed [16:0] kb_coef(input logic [1:0] idx);
    case (idx)
      2'd0: kb_coef = KB0;
      2'd1: kb_coef = KB1;
      2'd2: kb_coef = KB2;
      default: kb_coef = KB3;
    endcase
  endfunction

endpackage

// ===== hdl/t3vc_cfg_regs.sv =====
// Configuration register file of the type-3 voltage compensator.
// Depends on t3vc_pkg for the register indexes and the cfg_t bundle.

module t3vc_cfg_regs
  import t3vc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cal_gain         <= CAL_GAIN_RST;
      cfg.cal_offset       <= 13'sd0;
      cfg.vref             <= 12'd0;
      cfg.boost_max_duty   <= BOOST_MAX_RST;
      cfg.boost_floor_duty <= 13'd0;
      cfg.buck_run_duty    <= MAX_BUCK_RST;
      cfg.min_buck_duty    <= 13'd0;
      cfg.period           <= PERIOD_RST;
    end else if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_CAL_GAIN:   cfg.cal_gain         <= wr_data[12:0];
        REG_CAL_OFFSET: cfg.cal_offset       <= $signed(wr_data[12:0]);
        REG_VREF:       cfg.vref             <= wr_data[11:0];
        REG_BOOST_MAX:  cfg.boost_max_duty   <= wr_data[12:0];
        REG_BOOST_MIN:  cfg.boost_floor_duty <= wr_data[12:0];
        REG_BUCK_MAX:   cfg.buck_run_duty    <= wr_data[12:0];
        REG_BUCK_MIN:   cfg.min_buck_duty    <= wr_data[12:0];
        REG_PERIOD:     cfg.period           <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/t3vc_mac.sv =====
// Shared signed multiplier with a registered product and an accumulator.
// Depends on t3vc_pkg for the mac_ctl_t control bundle.

module t3vc_mac
  import t3vc_pkg::*;
(
  input  logic                clk,
  input  logic signed [32:0]  op_a,
  input  logic signed [16:0]  op_b,
  input  mac_ctl_t            ctl,
  output logic signed [49:0]  prod,
  output logic signed [47:0]  acc
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (ctl.acc_load) begin
      acc <= prod[47:0];
    end else if (ctl.acc_add) begin
      acc <= acc + prod[47:0];
    end
  end

endmodule

// ===== hdl/type3_voltage_compensator.sv =====
// Type-3 voltage compensator: one sample in, one set of duties and compares out.
// The ten products of a sample pass in turn through the one shared multiplier
// in t3vc_mac, and a new input transaction is taken only in ST_IDLE, once the
// last result has gone into the output register.
// Reset clears the error and output histories, loads the register defaults
// and empties the output register. Uses t3vc_pkg, t3vc_cfg_regs and t3vc_mac.

module type3_voltage_compensator
  import t3vc_pkg::*;
#(
  parameter int ADC_WIDTH = ADC_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // tdata: adc_sample [ADC_WIDTH-1:0], pwm_enable [ADC_WIDTH], zero padding above.
  input  logic [((ADC_WIDTH + 8) / 8) * 8-1:0] s_axis_tdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: boost_duty [12:0], buck_duty [25:13], buck_compare [41:26],
  // sample_compare [56:42], boost_compare [72:57], zero padding [79:73].
  output logic [79:0]                         m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [2:0]                          cfg_index,
  input  logic [15:0]                         cfg_data
);

  localparam int EW = (ADC_WIDTH + 4 > 16) ? ADC_WIDTH + 4 : 16;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_CAL   = 10'b0000000010,
    ST_ERR   = 10'b0000000100,
    ST_FB    = 10'b0000001000,
    ST_FF    = 10'b0000010000,
    ST_UPD   = 10'b0000100000,
    ST_CLAMP = 10'b0001000000,
    ST_CMP1  = 10'b0010000000,
    ST_CMP2  = 10'b0100000000,
    ST_DONE  = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic [2:0] cnt;

  cfg_t cfg;

  logic [ADC_WIDTH-1:0] adc_q;
  logic                 en_q;
  logic signed [15:0]   err_q;
  logic signed [35:0]   fb_sh;
  logic signed [15:0]   e_hist [3];
  logic signed [31:0]   u_hist [3];
  logic [12:0]          boost_q;
  logic [12:0]          buck_q;
  logic [15:0]          buck_cmp_q;
  logic [15:0]          boost_cmp_q;

  logic signed [32:0] op_a;
  logic signed [16:0] op_b;
  mac_ctl_t           mac_ctl;
  logic signed [49:0] prod;
  logic signed [47:0] acc;

  logic signed [EW-1:0] vout_w;
  logic signed [EW-1:0] err_w;
  logic signed [15:0]   err_sat;
  logic signed [39:0]   u_sum;
  logic signed [31:0]   u_new;
  logic signed [31:0]   clamp_hi;
  logic signed [31:0]   clamp_lo;
  logic [12:0]          buck_sel;
  logic [16:0]          scaled;
  logic                 out_load;

  t3vc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  t3vc_mac u_mac (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .ctl  (mac_ctl),
    .prod (prod),
    .acc  (acc)
  );

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign out_load      = (state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);
  assign buck_sel      = en_q ? cfg.buck_run_duty : cfg.min_buck_duty;
  assign scaled        = prod[28:12];

  always_comb begin
    vout_w = $signed({{(EW - ADC_WIDTH - 1){1'b0}}, prod[ADC_WIDTH+12:12]})
             + EW'(cfg.cal_offset);
    err_w  = $signed({{(EW - 12){1'b0}}, cfg.vref}) - vout_w;
    if (err_w > 32767) begin
      err_sat = 16'sh7fff;
    end else if (err_w < -32768) begin
      err_sat = -16'sh8000;
    end else begin
      err_sat = err_w[15:0];
    end
    u_sum    = 40'(fb_sh) + 40'(acc >>> 8);
    u_new    = u_sum[31:0];
    clamp_hi = (u_hist[0] > $signed({19'd0, cfg.boost_max_duty}))
               ? $signed({19'd0, cfg.boost_max_duty}) : u_hist[0];
    clamp_lo = (clamp_hi < $signed({19'd0, cfg.boost_floor_duty}))
               ? $signed({19'd0, cfg.boost_floor_duty}) : clamp_hi;
  end

  always_comb begin
    op_a = 33'sd0;
    op_b = 17'sd0;
    case (state)
      ST_CAL: begin
        op_a = $signed(33'(adc_q));
        op_b = $signed({4'd0, cfg.cal_gain});
      end
      ST_FB: begin
        case (cnt[1:0])
          2'd0: op_a = 33'(u_hist[0]);
          2'd1: op_a = 33'(u_hist[1]);
          2'd2: op_a = 33'(u_hist[2]);
          default: op_a = 33'sd0;
        endcase
        op_b = ka_coef(cnt[1:0]);
      end
      ST_FF: begin
        case (cnt[1:0])
          2'd0: op_a = 33'(err_q);
          2'd1: op_a = 33'(e_hist[0]);
          2'd2: op_a = 33'(e_hist[1]);
          default: op_a = 33'(e_hist[2]);
        endcase
        op_b = kb_coef(cnt[1:0]);
      end
      ST_CLAMP: begin
        op_a = $signed({20'd0, buck_sel});
        op_b = $signed({1'b0, cfg.period});
      end
      ST_CMP1: begin
        op_a = $signed({20'd0, boost_q});
        op_b = $signed({1'b0, cfg.period});
      end
      default: ;
    endcase
  end

  always_comb begin
    mac_ctl = '0;
    if (state == ST_FB || state == ST_FF) begin
      mac_ctl.acc_load = (cnt == 3'd1);
      mac_ctl.acc_add  = (cnt > 3'd1);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_axis_tvalid) state_next = ST_CAL;
      ST_CAL:   state_next = ST_ERR;
      ST_ERR:   state_next = ST_FB;
      ST_FB:    if (cnt == 3'd3) state_next = ST_FF;
      ST_FF:    if (cnt == 3'd4) state_next = ST_UPD;
      ST_UPD:   state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_CMP1;
      ST_CMP1:  state_next = ST_CMP2;
      ST_CMP2:  state_next = ST_DONE;
      ST_DONE:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= 3'd0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        cnt <= 3'd0;
      end else begin
        cnt <= cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        e_hist[i] <= 16'sd0;
        u_hist[i] <= 32'sd0;
      end
    end else if (state == ST_UPD) begin
      e_hist[2] <= e_hist[1];
      e_hist[1] <= e_hist[0];
      e_hist[0] <= err_q;
      u_hist[2] <= u_hist[1];
      u_hist[1] <= u_hist[0];
      u_hist[0] <= u_new;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      adc_q <= s_axis_tdata[ADC_WIDTH-1:0];
      en_q  <= s_axis_tdata[ADC_WIDTH];
    end
    if (state == ST_ERR) begin
      err_q <= err_sat;
    end
    if (state == ST_FF && cnt == 3'd0) begin
      fb_sh <= 36'(acc >>> 12);
    end
    if (state == ST_CLAMP) begin
      boost_q <= clamp_lo[12:0];
      buck_q  <= buck_sel;
    end
    if (state == ST_CMP1) begin
      buck_cmp_q <= scaled[16] ? 16'hffff : scaled[15:0];
    end
    if (state == ST_CMP2) begin
      boost_cmp_q <= (scaled > {1'b0, cfg.period}) ? 16'd0 : cfg.period - scaled[15:0];
    end
    if (out_load) begin
      m_axis_tdata <= {7'd0, boost_cmp_q, buck_cmp_q[15:1], buck_cmp_q, buck_q, boost_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("A second transaction was taken while one was in work.");

  a_cnt_fb: assert property (@(posedge clk) disable iff (rst)
    state == ST_FB |-> cnt <= 3'd3)
    else $error("The feedback term count ran past its last term.");

  a_sample_half: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[56:42] == m_axis_tdata[41:27])
    else $error("The sample compare is not half of the buck compare.");

  a_boost_limits: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (cfg.boost_floor_duty <= cfg.boost_max_duty)
    |-> m_axis_tdata[12:0] <= cfg.boost_max_duty
        && m_axis_tdata[12:0] >= cfg.boost_floor_duty)
    else $error("The boost duty lies outside its limits.");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_axis_tvalid && state == ST_IDLE)
    else $error("A finished result did not reach the output register.");

endmodule

// ===== bench/t3vc_checker.sv =====
// Checker for the type-3 voltage compensator: watches the register, sample and
// result channels, predicts every result and compares it. Depends on t3vc_pkg.
`timescale 1ns / 100ps

module t3vc_checker
  import t3vc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [79:0] m_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          outstanding,
  output int          results_seen
);

  typedef struct packed {
    logic [15:0] boost_compare;
    logic [14:0] sample_compare;
    logic [15:0] buck_compare;
    logic [12:0] buck_duty;
    logic [12:0] boost_duty;
  } duty_set_t;

  cfg_t               regs;
  logic signed [15:0] err_hist [3];
  logic signed [31:0] u_hist [3];
  duty_set_t          duty_q [$];
  int                 n_bad = 0;
  int                 n_seen = 0;

  function automatic duty_set_t compensate_sample(input logic [11:0] adc, input logic en);
    longint             vout, err, fb, ff, u_wide, boost, buck, buck_c, boost_s, boost_c;
    logic signed [31:0] u_w;
    duty_set_t          r;
    vout = ((longint'(adc) * longint'(regs.cal_gain)) >> 12) + longint'(regs.cal_offset);
    err = longint'(regs.vref) - vout;
    if (err > 32767) err = 32767;
    if (err < -32768) err = -32768;
    fb = longint'(KA1) * longint'(u_hist[0]) + longint'(KA2) * longint'(u_hist[1])
       + longint'(KA3) * longint'(u_hist[2]);
    ff = longint'(KB0) * err + longint'(KB1) * longint'(err_hist[0])
       + longint'(KB2) * longint'(err_hist[1]) + longint'(KB3) * longint'(err_hist[2]);
    u_wide = (fb >>> 12) + (ff >>> 8);
    u_w = u_wide[31:0];
    err_hist[2] = err_hist[1];
    err_hist[1] = err_hist[0];
    err_hist[0] = err[15:0];
    u_hist[2] = u_hist[1];
    u_hist[1] = u_hist[0];
    u_hist[0] = u_w;
    // The minimum limit is applied last, so it wins when the limits cross.
    boost = longint'(u_w);
    if (boost > longint'(regs.boost_max_duty)) boost = longint'(regs.boost_max_duty);
    if (boost < longint'(regs.boost_floor_duty)) boost = longint'(regs.boost_floor_duty);
    buck = en ? longint'(regs.buck_run_duty) : longint'(regs.min_buck_duty);
    buck_c = (buck * longint'(regs.period)) >> 12;
    if (buck_c > 65535) buck_c = 65535;
    boost_s = (boost * longint'(regs.period)) >> 12;
    boost_c = (boost_s > longint'(regs.period)) ? 0 : longint'(regs.period) - boost_s;
    r.boost_duty = boost[12:0];
    r.buck_duty = buck[12:0];
    r.buck_compare = buck_c[15:0];
    r.sample_compare = buck_c[15:1];
    r.boost_compare = boost_c[15:0];
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      n_bad++;
      if (n_bad <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    duty_set_t got;
    duty_set_t want;
    if (rst) begin
      regs.cal_gain = CAL_GAIN_RST;
      regs.cal_offset = '0;
      regs.vref = '0;
      regs.boost_max_duty = BOOST_MAX_RST;
      regs.boost_floor_duty = '0;
      regs.buck_run_duty = MAX_BUCK_RST;
      regs.min_buck_duty = '0;
      regs.period = PERIOD_RST;
      for (int i = 0; i < 3; i++) begin
        err_hist[i] = '0;
        u_hist[i] = '0;
      end
      duty_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[72:0];
        n_seen++;
        if (duty_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t: result transaction with no sample waiting, data %h",
                     $time, m_axis_tdata);
        end else begin
          want = duty_q.pop_front();
          check_field("boost_duty", want.boost_duty, got.boost_duty);
          check_field("buck_duty", want.buck_duty, got.buck_duty);
          check_field("buck_compare", want.buck_compare, got.buck_compare);
          check_field("sample_compare", want.sample_compare, got.sample_compare);
          check_field("boost_compare", want.boost_compare, got.boost_compare);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_CAL_GAIN:   regs.cal_gain = cfg_data[12:0];
          REG_CAL_OFFSET: regs.cal_offset = cfg_data[12:0];
          REG_VREF:       regs.vref = cfg_data[11:0];
          REG_BOOST_MAX:  regs.boost_max_duty = cfg_data[12:0];
          REG_BOOST_MIN:  regs.boost_floor_duty = cfg_data[12:0];
          REG_BUCK_MAX:   regs.buck_run_duty = cfg_data[12:0];
          REG_BUCK_MIN:   regs.min_buck_duty = cfg_data[12:0];
          REG_PERIOD:     regs.period = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        duty_q.push_back(compensate_sample(s_axis_tdata[11:0], s_axis_tdata[12]));
    end
    mismatches <= n_bad;
    results_seen <= n_seen;
    outstanding <= duty_q.size();
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the type-3 voltage compensator bench: clock, reset, register
// settings and sample stimulus. Depends on t3vc_pkg, t3vc_checker and type3_voltage_compensator.
`timescale 1ns / 100ps

module testbench;
  import t3vc_pkg::*;

  logic        clk;
  logic        rst = 1'b1;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int mismatches;
  int outstanding;
  int results_seen;

  bit calm = 1'b0;
  bit dirty_cfg = 1'b0;
  int n_sent = 0;
  int n_settings = 0;
  int cur_gain = 4096;
  int cur_off = 0;
  int cur_vref = 0;

  type3_voltage_compensator u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  t3vc_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .results_seen  (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) m_axis_tready <= calm || ($urandom_range(0, 99) >= 23);

  initial begin
    #5_000_000;
    $display("type3_voltage_compensator regression: fail");
    $finish;
  end

  function automatic logic [15:0] stray_bits(input logic [15:0] v, input int w);
    logic [15:0] m;
    m = 16'hFFFF << w;
    return dirty_cfg ? ((v & ~m) | (16'($urandom) & m)) : (v & ~m);
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(input int gain, input int off, input int vref, input int bmax,
                               input int bmin, input int kmax, input int kmin, input int per);
    write_reg(REG_CAL_GAIN, stray_bits(16'(gain), 13));
    write_reg(REG_CAL_OFFSET, stray_bits(16'(off), 13));
    write_reg(REG_VREF, stray_bits(16'(vref), 12));
    write_reg(REG_BOOST_MAX, stray_bits(16'(bmax), 13));
    write_reg(REG_BOOST_MIN, stray_bits(16'(bmin), 13));
    write_reg(REG_BUCK_MAX, stray_bits(16'(kmax), 13));
    write_reg(REG_BUCK_MIN, stray_bits(16'(kmin), 13));
    write_reg(REG_PERIOD, 16'(per));
    cfg_valid <= 1'b0;
    cur_gain = gain;
    cur_off = off;
    cur_vref = vref;
    n_settings++;
  endtask

  task automatic push_sample(input int adc, input bit en);
    if (!calm)
      while ($urandom_range(0, 99) < 23) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, en, 12'(adc)};
    do @(posedge clk); while (!s_axis_tready);
    n_sent++;
  endtask

  // Stops the sample stream and waits until every predicted result has arrived.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic random_settings();
    int gain, off, bmax, bmin, kmax, kmin;
    gain = ($urandom_range(0, 1) != 0) ? $urandom_range(3000, 5200) : $urandom_range(0, 8191);
    off = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 400) - 200
                                        : $urandom_range(0, 8191) - 4096;
    bmax = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 4096) : $urandom_range(0, 8191);
    bmin = ($urandom_range(0, 99) < 70) ? $urandom_range(0, bmax / 2) : $urandom_range(0, 8191);
    kmax = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 4096) : $urandom_range(0, 8191);
    kmin = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 4096) : $urandom_range(0, 8191);
    dirty_cfg = ($urandom_range(0, 99) < 25);
    load_settings(gain, off, $urandom_range(0, 4095), bmax, bmin, kmax, kmin,
                  $urandom_range(1, 65535));
    dirty_cfg = 1'b0;
  endtask

  // Mixes uniform samples, samples close to the regulation point and full-scale samples, so that
  // the duty does not sit on a limit all the time.
  task automatic run_random(input int count);
    int adc, tgt, sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        adc = $urandom_range(0, 4095);
      end else if (sel < 90) begin
        tgt = (cur_gain != 0) ? ((cur_vref - cur_off) * 4096) / cur_gain : 2048;
        adc = tgt + $urandom_range(0, 16) - 8;
        if (adc < 0) adc = 0;
        if (adc > 4095) adc = 4095;
      end else begin
        adc = ($urandom_range(0, 1) != 0) ? 4095 : 0;
      end
      push_sample(adc, $urandom_range(0, 1));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset register values.
    push_sample(0, 1'b1);
    push_sample(4095, 1'b0);
    push_sample(2048, 1'b1);
    push_sample(4095, 1'b1);
    push_sample(0, 1'b0);
    push_sample(1, 1'b1);
    push_sample(4094, 1'b0);
    drain();

    // Crossed boost limits, buck duty and period at their top, compare overflow.
    load_settings(8191, -4096, 4095, 0, 4096, 8191, 0, 65535);
    push_sample(0, 1'b1);
    push_sample(4095, 1'b0);
    push_sample(4095, 1'b1);
    push_sample(0, 1'b0);
    push_sample(2730, 1'b1);
    push_sample(1365, 1'b0);
    drain();

    // Zero gain, largest offset, smallest period.
    load_settings(0, 4095, 0, 8191, 0, 4096, 8191, 1);
    push_sample(4095, 1'b1);
    push_sample(0, 1'b0);
    push_sample(0, 1'b1);
    push_sample(4095, 1'b0);
    push_sample(1234, 1'b1);
    drain();

    load_settings(4096, 0, 2048, 3686, 0, 3809, 0, 32768);
    run_random(60);
    for (int p = 0; p < 5; p++) begin
      drain();
      random_settings();
      calm = (p == 2);
      run_random(75);
    end
    calm = 1'b0;
    drain();
    repeat (40) @(posedge clk);

    $display("Covered %0d samples under %0d register settings; %0d results compared.",
             n_sent, n_settings, results_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("type3_voltage_compensator regression: pass");
    end else begin
      $display("%0d mismatches, %0d results missing.", mismatches, outstanding);
      $display("type3_voltage_compensator regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/t3vc_pkg.sv
hdl/t3vc_cfg_regs.sv
hdl/t3vc_mac.sv
hdl/type3_voltage_compensator.sv
bench/t3vc_checker.sv
bench/testbench.sv
